FILE: hw/rtl/brt_pkg.sv
// Shared types and codes for the breakpoint range table.
// Holds the channel word layouts, the per-cell entry and query records
// and the command and status codes. No dependencies.
package brt_pkg;

    localparam logic [2:0] CMD_ADD         = 3'd0;
    localparam logic [2:0] CMD_REPLACE     = 3'd1;
    localparam logic [2:0] CMD_REMOVE_IDX  = 3'd2;
    localparam logic [2:0] CMD_REMOVE_ADDR = 3'd3;
    localparam logic [2:0] CMD_LOOKUP      = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOMATCH   = 2'd2;
    localparam logic [1:0] ST_BADINDEX  = 2'd3;

    localparam int FLAG_LOG_BIT = 4;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] address;
        logic [31:0] end_address;
        logic [31:0] query_size;
        logic [4:0]  flag_bits;
        logic [4:0]  entry_index;
    } req_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] result_index;
        logic       hit;
        logic       hit_log;
        logic [5:0] entry_count;
    } rsp_word_t;

    typedef struct packed {
        logic [31:0] range_start;
        logic [31:0] range_end;
        logic [4:0]  flags;
    } entry_t;

    // qend is 33 bits so a query past the top does not wrap
    typedef struct packed {
        logic [31:0] addr;
        logic [32:0] qend;
        logic [4:0]  need;
    } query_t;

    typedef struct packed {
        logic wr_en;
        logic shift_en;
        logic tok_adv;
        logic tok_clr;
    } cell_ctl_t;

endpackage

FILE: hw/rtl/brt_if.sv
// Valid/ready channel interfaces for the breakpoint range table.
// Depends on brt_pkg for the word layouts.
interface brt_req_if;
    logic               valid;
    logic               ready;
    brt_pkg::req_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface brt_rsp_if;
    logic               valid;
    logic               ready;
    brt_pkg::rsp_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/breakpoint_range_table.sv
// Breakpoint range table top level: command decode, scan control and the
// row of entry cells. Depends on brt_pkg, brt_if and brt_cell.
//
//   channel | dir | word       | accepted when
//   --------+-----+------------+------------------------
//   req     | in  | req_word_t | req.valid && req.ready
//   rsp     | out | rsp_word_t | rsp.valid && rsp.ready
//
// Add, replace, remove by index and unused codes finish in the accept
// cycle; the result is registered and shows on rsp in the next cycle.
// Lookup and remove by address walk a token down the cell row, one entry per
// cycle, and answer at the first matching entry or once the last entry is
// checked, so the table handles one command at a time.
// Reset clears the entry count, scan state and rsp valid; no clearing pass.
// A stalled rsp holds its word; req is taken again once the scan is done
// and the rsp register is free or being emptied.
module breakpoint_range_table #(
    parameter int ENTRIES = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    brt_req_if.sink    req,
    brt_rsp_if.source  rsp
);

    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      scan_reg, scan_next;
    brt_pkg::query_t    qry_reg, qry_next;
    logic               remove_reg, remove_next;
    logic               out_valid_reg, out_valid_next;
    brt_pkg::rsp_word_t out_reg, out_next;

    brt_pkg::cell_ctl_t ctl;
    logic [CW-1:0]      sel_idx;
    brt_pkg::entry_t    wr_data;
    logic               tok_start;

    logic               out_free;
    logic               acc;
    logic               full;
    logic               bad_idx;
    logic               last;
    logic               any_hit;
    logic               any_log;
    logic [31:0]        size_eff;

    brt_pkg::entry_t    data_row [ENTRIES];
    logic [ENTRIES-1:0] tok_row;
    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] log_vec;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign acc       = req.valid && req.ready;
    assign full      = count_reg == CW'(ENTRIES);
    assign bad_idx   = CMPW'(req.payload.entry_index) >= CMPW'(count_reg);
    assign last      = ({1'b0, scan_reg} + 1'b1) >= {1'b0, count_reg};
    assign any_hit   = |hit_vec;
    assign any_log   = |log_vec;
    assign size_eff  = (req.payload.query_size == 32'd0) ? 32'd1
                                                         : req.payload.query_size;

    assign wr_data.range_start = req.payload.address;
    assign wr_data.range_end   = req.payload.end_address;
    assign wr_data.flags       = req.payload.flag_bits;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        qry_next       = qry_reg;
        remove_next    = remove_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;
        ctl            = '0;
        sel_idx        = count_reg;
        tok_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.status = brt_pkg::ST_OK;
                    unique case (req.payload.command)
                        brt_pkg::CMD_ADD:
                        begin
                            if (full)
                            begin
                                out_next.status = brt_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.wr_en             = 1'b1;
                                sel_idx               = count_reg;
                                out_next.result_index = 5'(count_reg);
                                count_next            = count_reg + 1'b1;
                            end
                        end
                        brt_pkg::CMD_REPLACE:
                        begin
                            if (bad_idx)
                            begin
                                out_next.status = brt_pkg::ST_BADINDEX;
                            end
                            else
                            begin
                                ctl.wr_en = 1'b1;
                                sel_idx   = CW'(req.payload.entry_index);
                            end
                        end
                        brt_pkg::CMD_REMOVE_IDX:
                        begin
                            if (bad_idx)
                            begin
                                out_next.status = brt_pkg::ST_BADINDEX;
                            end
                            else
                            begin
                                ctl.shift_en = 1'b1;
                                sel_idx      = CW'(req.payload.entry_index);
                                count_next   = count_reg - 1'b1;
                            end
                        end
                        brt_pkg::CMD_REMOVE_ADDR, brt_pkg::CMD_LOOKUP:
                        begin
                            qry_next.addr = req.payload.address;
                            if (req.payload.command == brt_pkg::CMD_REMOVE_ADDR)
                            begin
                                qry_next.qend = {1'b0, req.payload.address};
                                qry_next.need = '0;
                                remove_next   = 1'b1;
                            end
                            else
                            begin
                                qry_next.qend = {1'b0, req.payload.address}
                                              + {1'b0, size_eff} - 33'd1;
                                qry_next.need = req.payload.flag_bits;
                                remove_next   = 1'b0;
                            end
                            if (count_reg == '0)
                            begin
                                out_next.status = brt_pkg::ST_NOMATCH;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                tok_start      = 1'b1;
                                ctl.tok_adv    = 1'b1;
                                scan_next      = '0;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    out_next.entry_count = 6'(count_next);
                end
            end
            S_SCAN:
            begin
                if (any_hit || last)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = '0;
                        ctl.tok_clr    = 1'b1;
                        state_next     = S_IDLE;
                        if (any_hit)
                        begin
                            out_next.status       = brt_pkg::ST_OK;
                            out_next.result_index = 5'(scan_reg);
                            out_next.hit          = 1'b1;
                            out_next.hit_log      = any_log;
                            if (remove_reg)
                            begin
                                ctl.shift_en = 1'b1;
                                sel_idx      = scan_reg;
                                count_next   = count_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            out_next.status = brt_pkg::ST_NOMATCH;
                        end
                        out_next.entry_count = 6'(count_next);
                    end
                end
                else
                begin
                    ctl.tok_adv = 1'b1;
                    scan_next   = scan_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            qry_reg       <= '0;
            remove_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            qry_reg       <= qry_next;
            remove_reg    <= remove_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic            tok_in;
        brt_pkg::entry_t nbr_data;

        if (i == 0)
        begin : g_head
            assign tok_in = tok_start;
        end
        else
        begin : g_body
            assign tok_in = tok_row[i-1];
        end

        if (i == ENTRIES - 1)
        begin : g_tail
            assign nbr_data = data_row[i];
        end
        else
        begin : g_mid
            assign nbr_data = data_row[i+1];
        end

        brt_cell #(
            .INDEX (i),
            .IDX_W (CW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .sel_idx  (sel_idx),
            .wr_data  (wr_data),
            .nbr_data (nbr_data),
            .query    (qry_reg),
            .tok_in   (tok_in),
            .tok_out  (tok_row[i]),
            .data_out (data_row[i]),
            .hit      (hit_vec[i]),
            .hit_log  (log_vec[i])
        );
    end

endmodule

FILE: hw/rtl/brt_cell.sv
// One table entry: holds a range and its flags, matches it against the
// broadcast query and passes the scan token down the row.
// Depends on brt_pkg.
module brt_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  brt_pkg::cell_ctl_t ctl,
    input  logic [IDX_W-1:0]   sel_idx,
    input  brt_pkg::entry_t    wr_data,
    input  brt_pkg::entry_t    nbr_data,
    input  brt_pkg::query_t    query,
    input  logic               tok_in,
    output logic               tok_out,
    output brt_pkg::entry_t    data_out,
    output logic               hit,
    output logic               hit_log
);

    brt_pkg::entry_t ent_reg;
    brt_pkg::entry_t ent_next;
    logic            tok_reg;
    logic            tok_next;
    logic            lo_ok;
    logic            hi_ok;
    logic            wraps;
    logic            flags_ok;
    logic            range_ok;

    always_comb
    begin
        ent_next = ent_reg;
        if (ctl.wr_en && (sel_idx == IDX_W'(INDEX)))
        begin
            ent_next = wr_data;
        end
        else if (ctl.shift_en && (sel_idx <= IDX_W'(INDEX)))
        begin
            ent_next = nbr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    always_comb
    begin
        tok_next = tok_reg;
        if (ctl.tok_clr)
        begin
            tok_next = 1'b0;
        end
        else if (ctl.tok_adv)
        begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // wrapped entry covers [start, top] and [0, end]
    assign lo_ok    = query.qend >= {1'b0, ent_reg.range_start};
    assign hi_ok    = query.addr <= ent_reg.range_end;
    assign wraps    = ent_reg.range_end < ent_reg.range_start;
    assign flags_ok = (ent_reg.flags & query.need) == query.need;
    assign range_ok = wraps ? (lo_ok || hi_ok) : (lo_ok && hi_ok);

    assign hit      = tok_reg && flags_ok && range_ok;
    assign hit_log  = hit && ent_reg.flags[brt_pkg::FLAG_LOG_BIT];
    assign tok_out  = tok_reg;
    assign data_out = ent_reg;

endmodule

FILE: hw/rtl/brt_checker.sv
// Port-level checks for the breakpoint range table, bound to the top level.
// Depends on brt_pkg and breakpoint_range_table.
module brt_checker #(
    parameter int ENTRIES = 32
) (
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input brt_pkg::rsp_word_t rsp_word
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
        else $error("rsp word changed while stalled");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.hit |-> rsp_word.status == brt_pkg::ST_OK)
        else $error("hit reported with a failing status");

    a_log_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_word.hit |-> !rsp_word.hit_log)
        else $error("log flag without a hit");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_word.status == brt_pkg::ST_FULL)
            |-> rsp_word.entry_count == 6'(ENTRIES))
        else $error("table full reported below capacity");

endmodule

bind breakpoint_range_table brt_checker #(
    .ENTRIES (ENTRIES)
) u_brt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_word  (rsp.payload)
);

FILE: bench/breakpoint_range_table_tb.sv
// Self-checking bench for breakpoint_range_table: directed and random command
// streams on the req channel, each rsp word checked against an in-bench table model.
// Depends on brt_pkg, brt_if and the breakpoint_range_table RTL.
module breakpoint_range_table_tb;

    localparam int TABLE_DEPTH = 32;
    localparam int RANDOM_CMDS = 1826;
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

    typedef struct {
        brt_pkg::req_word_t word;
        bit                 hold;   // wait for all responses before sending
    } queued_cmd_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    brt_pkg::req_word_t cmd_word = '0;
    logic               rsp_ready = 1'b0;

    brt_req_if req_ch();
    brt_rsp_if rsp_ch();

    assign req_ch.valid   = cmd_valid;
    assign req_ch.payload = cmd_word;
    assign rsp_ch.ready   = rsp_ready;

    breakpoint_range_table #(.ENTRIES(TABLE_DEPTH)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // table model state
    logic [31:0] bp_lo [TABLE_DEPTH];
    logic [31:0] bp_hi [TABLE_DEPTH];
    logic [4:0]  bp_flags [TABLE_DEPTH];
    int          used = 0;

    queued_cmd_t        pending_cmds[$];
    brt_pkg::rsp_word_t awaited_results[$];
    logic [31:0]        hot_addrs[$];
    int                 accepted = 0;
    int                 delivered = 0;
    int                 mismatches = 0;

    function automatic int first_cover(logic [31:0] a, logic [31:0] sz, logic [4:0] need);
        logic [32:0] qend;
        logic        lo_ok;
        logic        hi_ok;
        int          found;
        found = -1;
        // query end is 33 bits: never wraps back to low addresses
        qend = {1'b0, a} + {1'b0, ((sz == 32'd0) ? 32'd1 : sz)} - 33'd1;
        for (int i = 0; i < used && found < 0; i++)
        begin
            if ((bp_flags[i] & need) == need)
            begin
                lo_ok = qend >= {1'b0, bp_lo[i]};
                hi_ok = a <= bp_hi[i];
                if ((bp_hi[i] < bp_lo[i]) ? (lo_ok || hi_ok) : (lo_ok && hi_ok))
                    found = i;
            end
        end
        return found;
    endfunction

    function automatic void drop_entry(int k);
        for (int i = k + 1; i < used; i++)
        begin
            bp_lo[i - 1]    = bp_lo[i];
            bp_hi[i - 1]    = bp_hi[i];
            bp_flags[i - 1] = bp_flags[i];
        end
        used--;
    endfunction

    function automatic brt_pkg::rsp_word_t run_table_command(brt_pkg::req_word_t c);
        brt_pkg::rsp_word_t r;
        int                 hit_at;
        r = '0;
        case (c.command)
            brt_pkg::CMD_ADD:
                if (used >= TABLE_DEPTH)
                    r.status = brt_pkg::ST_FULL;
                else
                begin
                    bp_lo[used]    = c.address;
                    bp_hi[used]    = c.end_address;
                    bp_flags[used] = c.flag_bits;
                    r.result_index = used[4:0];
                    used++;
                end
            brt_pkg::CMD_REPLACE:
                if (c.entry_index >= used)
                    r.status = brt_pkg::ST_BADINDEX;
                else
                begin
                    bp_lo[c.entry_index]    = c.address;
                    bp_hi[c.entry_index]    = c.end_address;
                    bp_flags[c.entry_index] = c.flag_bits;
                end
            brt_pkg::CMD_REMOVE_IDX:
                if (c.entry_index >= used)
                    r.status = brt_pkg::ST_BADINDEX;
                else
                    drop_entry(c.entry_index);
            brt_pkg::CMD_REMOVE_ADDR, brt_pkg::CMD_LOOKUP:
            begin
                // remove by address: size 1, no required flags
                if (c.command == brt_pkg::CMD_LOOKUP)
                    hit_at = first_cover(c.address, c.query_size, c.flag_bits);
                else
                    hit_at = first_cover(c.address, 32'd1, 5'd0);
                if (hit_at < 0)
                    r.status = brt_pkg::ST_NOMATCH;
                else
                begin
                    r.result_index = hit_at[4:0];
                    r.hit          = 1'b1;
                    r.hit_log      = bp_flags[hit_at][brt_pkg::FLAG_LOG_BIT];
                    if (c.command == brt_pkg::CMD_REMOVE_ADDR)
                        drop_entry(hit_at);
                end
            end
            default: ;
        endcase
        r.entry_count = used[5:0];
        return r;
    endfunction

    function automatic brt_pkg::req_word_t make_cmd(logic [2:0] cmd, logic [31:0] a,
                                                    logic [31:0] e, logic [31:0] sz,
                                                    logic [4:0] f, logic [4:0] idx);
        brt_pkg::req_word_t w;
        w.command     = cmd;
        w.address     = a;
        w.end_address = e;
        w.query_size  = sz;
        w.flag_bits   = f;
        w.entry_index = idx;
        return w;
    endfunction

    function automatic void queue_cmd(brt_pkg::req_word_t w, bit hold);
        queued_cmd_t q;
        q.word = w;
        q.hold = hold;
        pending_cmds.push_back(q);
    endfunction

    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        case ($urandom_range(0, 9))
            0, 1, 2:
                if (hot_addrs.size() == 0)
                    a = $urandom;
                else
                    a = hot_addrs[$urandom_range(0, hot_addrs.size() - 1)]
                        + $urandom_range(0, 4) - 32'd2;
            3:
                case ($urandom_range(0, 3))
                    0: a = 32'h0000_0000;
                    1: a = 32'hFFFF_FFFF;
                    2: a = 32'h7FFF_FFFF;
                    default: a = 32'h8000_0000;
                endcase
            4, 5, 6: a = $urandom;
            default: a = $urandom_range(0, 32'h3FFF);
        endcase
        return a;
    endfunction

    function automatic logic [31:0] pick_end(logic [31:0] a);
        logic [31:0] e;
        case ($urandom_range(0, 19))
            0, 1, 2: e = a - $urandom_range(1, 4096);   // wraps around the top
            3, 4, 5: e = $urandom;
            6, 7: e = a;
            default: e = a + $urandom_range(0, 255);
        endcase
        return e;
    endfunction

    function automatic logic [31:0] pick_size();
        logic [31:0] s;
        case ($urandom_range(0, 19))
            0, 1, 2: s = 32'd0;
            3, 4: s = 32'hFFFF_FFFF;
            5, 6, 7: s = $urandom_range(1, 65536);
            8, 9: s = $urandom;
            default: s = $urandom_range(1, 8);
        endcase
        return s;
    endfunction

    function automatic logic [2:0] next_command(mix_t mix);
        int r;
        int lim_add;
        int lim_look;
        int lim_rep;
        int lim_ridx;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin lim_add = 55; lim_look = 80; lim_rep = 88; lim_ridx = 93; end
            MIX_DRAIN: begin lim_add = 10; lim_look = 35; lim_rep = 40; lim_ridx = 70; end
            default:   begin lim_add = 25; lim_look = 70; lim_rep = 80; lim_ridx = 88; end
        endcase
        if (r < lim_add)
            return brt_pkg::CMD_ADD;
        else if (r < lim_look)
            return brt_pkg::CMD_LOOKUP;
        else if (r < lim_rep)
            return brt_pkg::CMD_REPLACE;
        else if (r < lim_ridx)
            return brt_pkg::CMD_REMOVE_IDX;
        else if (r < 98)
            return brt_pkg::CMD_REMOVE_ADDR;
        return 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    endfunction

    // request driver: bursts with random gaps, valid held until taken
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid  <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!cmd_valid || req_ch.ready)
        begin
            if (cmd_valid)
            begin
                void'(pending_cmds.pop_front());
                accepted++;
            end
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                cmd_valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0 &&
                     (!pending_cmds[0].hold || accepted == delivered))
            begin
                cmd_valid <= 1'b1;
                cmd_word  <= pending_cmds[0].word;
                burst_left--;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // response stall pattern, re-picked after each random-length run
    logic [7:0] ready_pat = 8'hFF;
    int         pat_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            pat_left  = 0;
        end
        else
        begin
            if (pat_left == 0)
            begin
                pat_left = $urandom_range(16, 300);
                case ($urandom_range(0, 3))
                    0: ready_pat = 8'hFF;
                    1: ready_pat = 8'h01;
                    2: ready_pat = 8'hAA;
                    default: ready_pat = 8'($urandom_range(0, 255)) | 8'h01;
                endcase
            end
            ready_pat = {ready_pat[0], ready_pat[7:1]};
            rsp_ready <= ready_pat[0];
            pat_left--;
        end
    end

    task automatic report_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // monitor: check response words first, then predict newly taken commands
    always @(posedge clk)
    begin
        brt_pkg::rsp_word_t want;
        brt_pkg::rsp_word_t got;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = rsp_ch.payload;
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected response word, expected none, actual %h",
                             $time, got);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    report_field("status", want.status, got.status);
                    report_field("result_index", want.result_index, got.result_index);
                    report_field("hit", want.hit, got.hit);
                    report_field("hit_log", want.hit_log, got.hit_log);
                    report_field("entry_count", want.entry_count, got.entry_count);
                end
                delivered <= delivered + 1;
            end
            if (req_ch.valid && req_ch.ready)
                awaited_results.push_back(run_table_command(req_ch.payload));
        end
    end

    initial
    begin
        #4_000_000;
        $display("breakpoint_range_table verification failed");
        $finish;
    end

    initial
    begin
        brt_pkg::req_word_t w;
        mix_t               mix;
        int                 mix_left;
        int                 est;
        mix      = MIX_FILL;
        mix_left = 0;
        est      = 0;

        // empty table
        queue_cmd(make_cmd(brt_pkg::CMD_LOOKUP, 32'h0, 32'h0, 32'd1, 5'h00, 5'd0), 1'b0);
        queue_cmd(make_cmd(brt_pkg::CMD_REMOVE_ADDR, 32'h0, 32'h0, 32'd1, 5'h00, 5'd0),
                  1'b0);
        queue_cmd(make_cmd(brt_pkg::CMD_REMOVE_IDX, 32'h0, 32'h0, 32'd1, 5'h00, 5'd0),
                  1'b0);
        queue_cmd(make_cmd(brt_pkg::CMD_REPLACE, 32'h0, 32'h0, 32'd1, 5'h1F, 5'd0), 1'b0);
        // plain, wrapping, whole-space and top-byte entries
        queue_cmd(make_cmd(brt_pkg::CMD_ADD, 32'h1000, 32'h1FFF, 32'd1, 5'h1F, 5'd0), 1'b0);
        queue_cmd(make_cmd(brt_pkg::CMD_ADD, 32'hFFFF_FF00, 32'h0000_00FF, 32'd1, 5'h03,
                           5'd0), 1'b0);
        queue_cmd(make_cmd(brt_pkg::CMD_ADD, 32'h0, 32'hFFFF_FFFF, 32'd1, 5'h00, 5'd0),
                  1'b0);
        queue_cmd(make_cmd(brt_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 5'h10,
                           5'd0), 1'b0);
        queue_cmd(make_cmd(brt_pkg::CMD_LOOKUP, 32'h0800, 32'h0, 32'h1000, 5'h1F, 5'd0),
                  1'b0);
        // zero size counts as one byte
        queue_cmd(make_cmd(brt_pkg::CMD_LOOKUP, 32'h10, 32'h0, 32'd0, 5'h03, 5'd0), 1'b0);
        // query running past the top of the address space
        queue_cmd(make_cmd(brt_pkg::CMD_LOOKUP, 32'hFFFF_FFF0, 32'h0, 32'hFFFF_FFFF, 5'h10,
                           5'd0), 1'b0);
        queue_cmd(make_cmd(brt_pkg::CMD_LOOKUP, 32'h5000, 32'h0, 32'd1, 5'h1F, 5'd0), 1'b0);
        queue_cmd(make_cmd(brt_pkg::CMD_LOOKUP, 32'h5000, 32'h0, 32'd1, 5'h00, 5'd0), 1'b0);
        queue_cmd(make_cmd(brt_pkg::CMD_REPLACE, 32'h2000, 32'h2003, 32'd1, 5'h11, 5'd2),
                  1'b0);
        queue_cmd(make_cmd(brt_pkg::CMD_REPLACE, 32'h0, 32'h0, 32'd1, 5'h00, 5'd31), 1'b0);
        queue_cmd(make_cmd(brt_pkg::CMD_REMOVE_ADDR, 32'hFFFF_FFFF, 32'h0, 32'd1, 5'h00,
                           5'd0), 1'b0);
        queue_cmd(make_cmd(brt_pkg::CMD_REMOVE_IDX, 32'h0, 32'h0, 32'd1, 5'h00, 5'd31),
                  1'b0);
        queue_cmd(make_cmd(brt_pkg::CMD_REMOVE_IDX, 32'h0, 32'h0, 32'd1, 5'h00, 5'd0),
                  1'b0);
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            queue_cmd(make_cmd(3'(c), '1, '1, '1, '1, '1), 1'b0);
        queue_cmd(make_cmd(brt_pkg::CMD_LOOKUP, 32'h2002, 32'h0, 32'd4, 5'h10, 5'd0), 1'b0);
        queue_cmd(make_cmd(brt_pkg::CMD_REMOVE_ADDR, 32'h1234_5678, 32'h0, 32'd1, 5'h00,
                           5'd0), 1'b0);
        est = 2;

        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (mix_left == 0)
            begin
                mix_left = $urandom_range(40, 150);
                mix = mix_t'($urandom_range(0, 2));
            end
            mix_left--;
            w.command     = next_command(mix);
            w.address     = pick_addr();
            w.end_address = pick_end(w.address);
            w.query_size  = pick_size();
            if (w.command != brt_pkg::CMD_LOOKUP)
                w.flag_bits = 5'($urandom_range(0, 31));
            else if ($urandom_range(0, 9) < 4)
                w.flag_bits = 5'h00;
            else if ($urandom_range(0, 1) == 0)
                w.flag_bits = 5'h01 << $urandom_range(0, 4);
            else
                w.flag_bits = 5'($urandom_range(0, 31));
            if ($urandom_range(0, 4) != 0 && est > 0)
                w.entry_index = 5'($urandom_range(0, est - 1));
            else
                w.entry_index = 5'($urandom_range(0, 31));

            // rough entry count, only to steer indexes toward used entries
            case (w.command)
                brt_pkg::CMD_ADD:
                    if (est < TABLE_DEPTH)
                        est++;
                brt_pkg::CMD_REMOVE_IDX:
                    if (w.entry_index < est)
                        est--;
                brt_pkg::CMD_REMOVE_ADDR:
                    if (est > 0)
                        est--;
                default: ;
            endcase
            if (w.command == brt_pkg::CMD_ADD || w.command == brt_pkg::CMD_REPLACE)
            begin
                hot_addrs.push_back(w.address);
                hot_addrs.push_back(w.end_address);
                while (hot_addrs.size() > 48)
                    void'(hot_addrs.pop_front());
            end
            queue_cmd(w, (n % 250) == 0);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || accepted != delivered);
        repeat (TABLE_DEPTH + 8) @(negedge clk);

        if (awaited_results.size() != 0)
            $display("%0t: %0d expected response words never arrived",
                     $time, awaited_results.size());
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("breakpoint_range_table verification clean");
        else
            $display("breakpoint_range_table verification failed");
        $finish;
    end

endmodule
